[rtl/ddn_pkg.sv]
`timescale 1ns / 1ps
package ddn_pkg;
   localparam int CfgIdxW = 3;
   localparam logic [CfgIdxW-1:0] REG_SCORE_TH = 3'd0;
   localparam logic [CfgIdxW-1:0] REG_IOU_TH   = 3'd1;
   localparam logic [CfgIdxW-1:0] REG_INV_SCL  = 3'd2;
   localparam logic [CfgIdxW-1:0] REG_PAD_L    = 3'd3;
   localparam logic [CfgIdxW-1:0] REG_PAD_T    = 3'd4;
   localparam logic [CfgIdxW-1:0] REG_IMG_W    = 3'd5;
   localparam logic [CfgIdxW-1:0] REG_IMG_H    = 3'd6;
   localparam int MaxResults = 64;

   typedef struct packed {
      logic [15:0] score_th;
      logic [15:0] iou_th;
      logic [15:0] inv_scale;
      logic [10:0] pad_left;
      logic [10:0] pad_top;
      logic [11:0] img_w;
      logic [11:0] img_h;
   } cfg_type;

   // Decoded candidate handed from front to back.
   typedef struct packed {
      logic        keep;
      logic        last;
      logic [1:0]  cls;
      logic [15:0] score;
      logic [15:0] l;
      logic [15:0] t;
      logic [15:0] r;
      logic [15:0] b;
   } cand_type;

   // One store entry: class, score and image-pixel edges.
   typedef struct packed {
      logic [1:0]  cls;
      logic [15:0] score;
      logic [15:0] l;
      logic [15:0] t;
      logic [15:0] r;
      logic [15:0] b;
   } entry_type;

   typedef struct packed {
      logic        valid_res;
      logic [1:0]  class_index;
      logic [15:0] confidence;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
      logic        overflow;
      logic        last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD, ST_SCAN_RD, ST_SCAN_PROD, ST_SCAN_TEST, ST_PICK,
      ST_EMIT_ORD, ST_EMIT_CAND, ST_EMIT_OUT, ST_CLEAR
   } back_state_type;

   // Edge in Q.5 -> Q.4 image pixels; product is one 17x16 multiply.
   function automatic logic [15:0] map_edge(input logic signed [17:0] v5,
                                            input logic [15:0] inv,
                                            input logic [11:0] bound);
      logic [33:0] p;
      logic [33:0] lim;
      begin
         p   = ({17'd0, v5[16:0]} * {18'd0, inv} + 34'd4096) >> 13;
         lim = {18'd0, bound, 4'd0};
         if (v5 <= 18'sd0) map_edge = 16'd0;
         else if (p > lim) map_edge = lim[15:0];
         else map_edge = p[15:0];
      end
   endfunction
endpackage

[rtl/ddn_front.sv]
`timescale 1ns / 1ps
module ddn_front import ddn_pkg::*; #(
   parameter int CLASS_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [14:0] cx,
   input  logic [14:0] cy,
   input  logic [14:0] bw,
   input  logic [14:0] bh,
   input  logic [63:0] scores,
   input  logic        last,
   output logic        out_valid,
   input  logic        out_ready,
   output cand_type    out_cand
);
   // stage 1: class pick, edges in Q.5
   logic        s1_v_ff, s1_v_in;
   logic        s1_keep_ff, s1_last_ff;
   logic [1:0]  s1_cls_ff;
   logic [15:0] s1_score_ff;
   logic signed [17:0] s1_e_ff [4];
   logic        s2_v_ff;
   cand_type    s2_ff, s2_in;
   logic        adv;
   logic [15:0] best;
   logic [1:0]  cls;
   logic signed [17:0] px, py, c2x, c2y;

   assign adv = !s2_v_ff || out_ready;
   assign in_ready = !s1_v_ff || adv;
   assign s1_v_in = in_valid && in_ready;

   always_comb begin
      best = scores[15:0];
      cls = 2'd0;
      for (int k = 1; k < CLASS_COUNT; k++) begin
         if (scores[16*k +: 16] > best) begin
            best = scores[16*k +: 16];
            cls = 2'(k);
         end
      end
      px  = 18'(cfg.pad_left) <<< 5;
      py  = 18'(cfg.pad_top) <<< 5;
      c2x = 18'(cx) <<< 1;
      c2y = 18'(cy) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (in_ready) s1_v_ff <= s1_v_in;
         if (adv) s2_v_ff <= s1_v_ff;
      end
      if (s1_v_in) begin
         s1_keep_ff  <= best >= cfg.score_th;
         s1_last_ff  <= last;
         s1_cls_ff   <= cls;
         s1_score_ff <= best;
         s1_e_ff[0]  <= c2x - 18'(bw) - px;
         s1_e_ff[1]  <= c2y - 18'(bh) - py;
         s1_e_ff[2]  <= c2x + 18'(bw) - px;
         s1_e_ff[3]  <= c2y + 18'(bh) - py;
      end
      if (adv && s1_v_ff) s2_ff <= s2_in;
   end

   always_comb begin
      s2_in.l = map_edge(s1_e_ff[0], cfg.inv_scale, cfg.img_w);
      s2_in.t = map_edge(s1_e_ff[1], cfg.inv_scale, cfg.img_h);
      s2_in.r = map_edge(s1_e_ff[2], cfg.inv_scale, cfg.img_w);
      s2_in.b = map_edge(s1_e_ff[3], cfg.inv_scale, cfg.img_h);
      s2_in.keep = s1_keep_ff && ({1'b0, s2_in.r} >= {1'b0, s2_in.l} + 17'd32)
                   && ({1'b0, s2_in.b} >= {1'b0, s2_in.t} + 17'd32);
      s2_in.last  = s1_last_ff;
      s2_in.cls   = s1_cls_ff;
      s2_in.score = s1_score_ff;
   end

   assign out_valid = s2_v_ff;
   assign out_cand  = s2_ff;
endmodule

[rtl/ddn_queue.sv]
`timescale 1ns / 1ps
module ddn_queue import ddn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  cand_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output cand_type head_data
);
   cand_type   mem_ff [4];
   logic [2:0] wp_ff, rp_ff;
   logic       wr, rd;

   assign in_ready  = (wp_ff - rp_ff) != 3'd4;
   assign out_valid = wp_ff != rp_ff;
   assign head_data = mem_ff[rp_ff[1:0]];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 3'd1;
         if (rd) rp_ff <= rp_ff + 3'd1;
      end
      if (wr) mem_ff[wp_ff[1:0]] <= in_data;
   end
endmodule

[rtl/ddn_back.sv]
`timescale 1ns / 1ps
// Simple dual-port RAM, registered read.
module ddn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

module ddn_back import ddn_pkg::*; #(
   parameter int MAX_CANDIDATES = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic [15:0] iou_th,
   input  logic     in_valid,
   output logic     in_ready,
   input  cand_type in_cand,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);
   localparam int IW = $clog2(MAX_CANDIDATES);
   localparam int CW = $clog2(MAX_CANDIDATES + 1);

   // Store holds survivors in arrival order. At frame end each pass picks the
   // best live entry (first one on equal scores) and suppresses against the
   // previous pick, which gives the same order as a score-sorted greedy NMS.
   back_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           ovf_ff, ovf_in;
   logic [MAX_CANDIDATES-1:0] gone_ff, gone_in;   // kept or suppressed
   logic [CW-1:0]  j_ff, j_in;                     // scan index
   logic [CW-1:0]  kept_ff, kept_in;
   logic [CW-1:0]  k_ff, k_in;                     // emit index
   logic           have_sel_ff, have_sel_in;
   entry_type      sel_ff, sel_in;                 // box suppressing this pass
   logic           found_ff, found_in;
   logic [IW-1:0]  best_idx_ff, best_idx_in;
   entry_type      best_ff, best_in;
   logic [33:0]    inter_ff, uni_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           rv_ff, rv_in;

   logic           st_we;
   logic [IW-1:0]  st_waddr, st_raddr;
   entry_type      st_wdata, st_rdata;
   logic           ord_we;
   logic [IW-1:0]  ord_rdata;

   logic [15:0]    il, it, ir, ib, iw, ih, aw, ah, bw, bh;
   logic [31:0]    inter_w, area_a, area_b;
   logic [49:0]    lhs, rhs;
   logic           ov_hit, emitting, too_many;
   logic [CW-1:0]  emit_n;

   assign st_wdata = '{cls: in_cand.cls, score: in_cand.score, l: in_cand.l,
                       t: in_cand.t, r: in_cand.r, b: in_cand.b};
   assign st_waddr = cnt_ff[IW-1:0];
   assign emitting = (state_ff == ST_EMIT_ORD) || (state_ff == ST_EMIT_CAND)
                     || (state_ff == ST_EMIT_OUT);
   assign st_raddr = emitting ? ord_rdata : j_ff[IW-1:0];

   ddn_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_CANDIDATES)) u_store (
      .clock, .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   // store index of each kept box, in emit order
   ddn_ram #(.WIDTH(IW), .DEPTH(MAX_CANDIDATES)) u_order (
      .clock, .wr_en(ord_we), .wr_addr(kept_ff[IW-1:0]), .wr_data(best_idx_ff),
      .rd_addr(k_ff[IW-1:0]), .rd_data(ord_rdata)
   );

   // overlap of the selected box against the entry just read
   always_comb begin
      il = sel_ff.l > st_rdata.l ? sel_ff.l : st_rdata.l;
      it = sel_ff.t > st_rdata.t ? sel_ff.t : st_rdata.t;
      ir = sel_ff.r < st_rdata.r ? sel_ff.r : st_rdata.r;
      ib = sel_ff.b < st_rdata.b ? sel_ff.b : st_rdata.b;
      iw = ir > il ? ir - il : 16'd0;
      ih = ib > it ? ib - it : 16'd0;
      aw = sel_ff.r > sel_ff.l ? sel_ff.r - sel_ff.l : 16'd0;
      ah = sel_ff.b > sel_ff.t ? sel_ff.b - sel_ff.t : 16'd0;
      bw = st_rdata.r > st_rdata.l ? st_rdata.r - st_rdata.l : 16'd0;
      bh = st_rdata.b > st_rdata.t ? st_rdata.b - st_rdata.t : 16'd0;
      inter_w = iw * ih;
      area_a = aw * ah;
      area_b = bw * bh;
      // exact test: inter * 65536 > iou_th * union
      lhs = {inter_ff, 16'd0};
      rhs = 50'(uni_ff) * 50'(iou_th);
      ov_hit = lhs > rhs;
      too_many = 32'(kept_ff) > 32'(MaxResults);
      emit_n = too_many ? CW'(MaxResults) : kept_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         gone_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         gone_ff <= gone_in;
         rv_ff <= rv_in;
      end
      j_ff <= j_in;
      kept_ff <= kept_in;
      k_ff <= k_in;
      have_sel_ff <= have_sel_in;
      sel_ff <= sel_in;
      found_ff <= found_in;
      best_idx_ff <= best_idx_in;
      best_ff <= best_in;
      rsp_ff <= rsp_in;
      inter_ff <= 34'(inter_w);
      uni_ff <= 34'(area_a) + 34'(area_b) - 34'(inter_w);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      gone_in = gone_ff;
      j_in = j_ff;
      kept_in = kept_ff;
      k_in = k_ff;
      have_sel_in = have_sel_ff;
      sel_in = sel_ff;
      found_in = found_ff;
      best_idx_in = best_idx_ff;
      best_in = best_ff;
      rsp_in = rsp_ff;
      rv_in = rv_ff && !rsp_ready;
      in_ready = 1'b0;
      st_we = 1'b0;
      ord_we = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            in_ready = 1'b1;
            if (in_valid) begin
               if (in_cand.keep) begin
                  if (cnt_ff == CW'(MAX_CANDIDATES)) ovf_in = 1'b1;
                  else begin
                     st_we = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               if (in_cand.last) begin
                  j_in = '0;
                  kept_in = '0;
                  have_sel_in = 1'b0;
                  found_in = 1'b0;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (j_ff == cnt_ff) state_in = ST_PICK;
            else if (gone_ff[j_ff[IW-1:0]]) j_in = j_ff + 1'b1;
            else state_in = ST_SCAN_PROD;
         end
         ST_SCAN_PROD: state_in = ST_SCAN_TEST;
         ST_SCAN_TEST: begin
            if (have_sel_ff && st_rdata.cls == sel_ff.cls && ov_hit) begin
               gone_in[j_ff[IW-1:0]] = 1'b1;
            end else if (!found_ff || st_rdata.score > best_ff.score) begin
               found_in = 1'b1;
               best_idx_in = j_ff[IW-1:0];
               best_in = st_rdata;
            end
            j_in = j_ff + 1'b1;
            state_in = ST_SCAN_RD;
         end
         ST_PICK: begin
            if (found_ff) begin
               gone_in[best_idx_ff] = 1'b1;
               ord_we = 1'b1;
               kept_in = kept_ff + 1'b1;
               sel_in = best_ff;
               have_sel_in = 1'b1;
               found_in = 1'b0;
               j_in = '0;
               state_in = ST_SCAN_RD;
            end else begin
               k_in = '0;
               state_in = ST_EMIT_ORD;
            end
         end
         ST_EMIT_ORD: begin
            if (kept_ff != '0) begin
               state_in = ST_EMIT_CAND;
            end else if (!rv_ff || rsp_ready) begin
               // empty frame: one invalid item
               rsp_in = '0;
               rsp_in.overflow = ovf_ff;
               rsp_in.last_result = 1'b1;
               rv_in = 1'b1;
               state_in = ST_CLEAR;
            end
         end
         ST_EMIT_CAND: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rsp_in.valid_res = 1'b1;
               rsp_in.class_index = st_rdata.cls;
               rsp_in.confidence = st_rdata.score;
               rsp_in.left = st_rdata.l;
               rsp_in.top = st_rdata.t;
               rsp_in.right = st_rdata.r;
               rsp_in.bottom = st_rdata.b;
               rsp_in.overflow = ovf_ff || too_many;
               rsp_in.last_result = (k_ff == emit_n - 1'b1);
               rv_in = 1'b1;
               k_in = k_ff + 1'b1;
               if (k_ff == emit_n - 1'b1) state_in = ST_CLEAR;
               else state_in = ST_EMIT_ORD;
            end
         end
         ST_CLEAR: begin
            gone_in = '0;
            cnt_in = '0;
            ovf_in = 1'b0;
            state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp = rsp_ff;
endmodule

[rtl/detection_decode_nms.sv]
`timescale 1ns / 1ps
// Path: an accepted anchor passes two decode stages and one queue slot before it
// is written to the store; the store takes one anchor per cycle while loading.
// Frame end: each NMS pass reads, multiplies and tests every live entry, skips
// kept or suppressed entries, then picks; one pass per kept box plus a final one.
// Results then leave one at a time via order read, store read and output steps.
// Reset: synchronous, active high; config registers return to defaults, store empty.
module detection_decode_nms import ddn_pkg::*; #(
   parameter int MAX_CANDIDATES = 64,
   parameter int CLASS_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [14:0] req_center_x,
   input  logic [14:0] req_center_y,
   input  logic [14:0] req_box_width,
   input  logic [14:0] req_box_height,
   input  logic [15:0] req_score_zero,
   input  logic [15:0] req_score_one,
   input  logic [15:0] req_score_two,
   input  logic [15:0] req_score_three,
   input  logic        req_last_anchor,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_valid_res,
   output logic [1:0]  rsp_class_index,
   output logic [15:0] rsp_confidence,
   output logic [15:0] rsp_left,
   output logic [15:0] rsp_top,
   output logic [15:0] rsp_right,
   output logic [15:0] rsp_bottom,
   output logic        rsp_overflow,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CfgIdxW-1:0] csr_index,
   input  logic [15:0] csr_data
);
   cfg_type  cfg_ff;
   cand_type f_cand, q_cand;
   logic     f_v, f_r, q_v, q_r, in_ready, rv;
   rsp_type  rsp;

   // Config registers, written whenever the channel is offered.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_th  <= 16'd16384;
         cfg_ff.iou_th    <= 16'd29491;
         cfg_ff.inv_scale <= 16'd4096;
         cfg_ff.pad_left  <= '0;
         cfg_ff.pad_top   <= '0;
         cfg_ff.img_w     <= 12'd640;
         cfg_ff.img_h     <= 12'd640;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SCORE_TH: cfg_ff.score_th  <= csr_data;
            REG_IOU_TH:   cfg_ff.iou_th    <= csr_data;
            REG_INV_SCL:  cfg_ff.inv_scale <= csr_data;
            REG_PAD_L:    cfg_ff.pad_left  <= csr_data[10:0];
            REG_PAD_T:    cfg_ff.pad_top   <= csr_data[10:0];
            REG_IMG_W:    cfg_ff.img_w     <= csr_data[11:0];
            REG_IMG_H:    cfg_ff.img_h     <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   assign full = !in_ready;

   ddn_front #(.CLASS_COUNT(CLASS_COUNT)) u_front (
      .clock, .reset, .cfg(cfg_ff), .in_valid(push), .in_ready,
      .cx(req_center_x), .cy(req_center_y), .bw(req_box_width),
      .bh(req_box_height),
      .scores({req_score_three, req_score_two, req_score_one, req_score_zero}),
      .last(req_last_anchor), .out_valid(f_v), .out_ready(f_r), .out_cand(f_cand)
   );

   // Queue decouples decode from the store sequencer.
   ddn_queue u_queue (
      .clock, .reset, .in_valid(f_v), .in_ready(f_r), .in_data(f_cand),
      .out_valid(q_v), .out_ready(q_r), .head_data(q_cand)
   );

   ddn_back #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_back (
      .clock, .reset, .iou_th(cfg_ff.iou_th), .in_valid(q_v), .in_ready(q_r),
      .in_cand(q_cand), .rsp_valid(rv), .rsp_ready(pop), .rsp
   );

   assign empty           = !rv;
   assign rsp_valid_res   = rsp.valid_res;
   assign rsp_class_index = rsp.class_index;
   assign rsp_confidence  = rsp.confidence;
   assign rsp_left        = rsp.left;
   assign rsp_top         = rsp.top;
   assign rsp_right       = rsp.right;
   assign rsp_bottom      = rsp.bottom;
   assign rsp_overflow    = rsp.overflow;
   assign rsp_last_result = rsp.last_result;
endmodule

[rtl/ddn_checker.sv]
`timescale 1ns / 1ps
module ddn_sva (
   input logic clock,
   input logic reset,
   input logic empty,
   input logic pop,
   input logic rsp_valid_res,
   input logic rsp_last_result,
   input logic rsp_overflow
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty) else $error("result dropped while waiting");
   a_inv_last: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_valid_res |-> rsp_last_result)
      else $error("empty-frame item not marked last");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> $stable(rsp_overflow)) else $error("overflow moved");
endmodule

bind detection_decode_nms ddn_sva u_chk (
   .clock, .reset, .empty, .pop, .rsp_valid_res, .rsp_last_result, .rsp_overflow
);
